@@ rtl/cla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cla_pkg;

  // Tokenizer modes
  localparam logic [2:0] ModeIdle     = 3'd0;
  localparam logic [2:0] ModeWord     = 3'd1;
  localparam logic [2:0] ModeWordEsc  = 3'd2;
  localparam logic [2:0] ModeQuote    = 3'd3;
  localparam logic [2:0] ModeQuoteEsc = 3'd4;

  // Byte codes
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;

  // Result kinds
  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Output queue depth: two results per byte, plus slack for a full-rate stream
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // Decode of one byte: result count, up to two results, next mode
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
    logic [2:0] mode;
  } step_t;

endpackage

`default_nettype wire

@@ rtl/cla_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cla_step (
  input  var cla_pkg::in_t   item_i,
  input  var logic [2:0]     mode_i,
  output var cla_pkg::step_t step_o
);

  logic [2:0] m;
  logic       cv;
  logic [7:0] cb;
  logic       bv;
  logic       ev;
  logic       blank;
  cla_pkg::out_t a_item;
  cla_pkg::out_t b_item;
  cla_pkg::out_t e_item;

  assign blank = item_i.ch inside {cla_pkg::ChSpace, cla_pkg::ChTab,
                                   cla_pkg::ChLf, cla_pkg::ChCr};

  always_comb begin
    m  = (mode_i > cla_pkg::ModeQuoteEsc) ? cla_pkg::ModeIdle : mode_i;
    cv = 1'b0;
    cb = item_i.ch;
    bv = 1'b0;
    ev = 1'b0;
    // a zero byte is no byte at all
    if (item_i.ch != 8'd0) begin
      case (m)
        cla_pkg::ModeIdle: begin
          if (blank) begin
            m = cla_pkg::ModeIdle;
          end else if (item_i.ch == cla_pkg::ChDquote) begin
            m = cla_pkg::ModeQuote;
          end else if (item_i.ch == cla_pkg::ChBslash) begin
            m = cla_pkg::ModeWordEsc;
          end else begin
            cv = 1'b1;
            m  = cla_pkg::ModeWord;
          end
        end
        cla_pkg::ModeWord: begin
          if (blank) begin
            ev = 1'b1;  // blank closes the token; no line-end marker can follow
            m  = cla_pkg::ModeIdle;
          end else if (item_i.ch == cla_pkg::ChBslash) begin
            m = cla_pkg::ModeWordEsc;
          end else begin
            cv = 1'b1;
          end
        end
        cla_pkg::ModeWordEsc: begin
          cv = 1'b1;
          m  = cla_pkg::ModeWord;
        end
        cla_pkg::ModeQuote: begin
          if (item_i.ch == cla_pkg::ChBslash) begin
            m = cla_pkg::ModeQuoteEsc;
          end else if (item_i.ch == cla_pkg::ChDquote) begin
            ev = 1'b1;
            m  = cla_pkg::ModeIdle;
          end else begin
            cv = 1'b1;
          end
        end
        default: begin
          cv = 1'b1;
          m  = cla_pkg::ModeQuote;
        end
      endcase
    end
    // line end: keep a pending backslash inside quotes, close any open token
    if (item_i.line_end) begin
      bv = (m == cla_pkg::ModeQuoteEsc);
      ev = ev | (m != cla_pkg::ModeIdle);
      m  = cla_pkg::ModeIdle;
    end
  end

  always_comb begin
    a_item = '{kind: cla_pkg::KindChar, out_byte: cb, last_of_run: 1'b0};
    b_item = '{kind: cla_pkg::KindChar, out_byte: cla_pkg::ChBslash, last_of_run: 1'b0};
    e_item = '{kind: cla_pkg::KindEnd, out_byte: 8'd0, last_of_run: 1'b0};

    step_o.mode = m;
    step_o.cnt  = 2'd0;
    step_o.r0   = e_item;
    step_o.r1   = e_item;
    if (cv) begin
      step_o.r0 = a_item;
      step_o.r1 = bv ? b_item : e_item;
      step_o.cnt = (bv || ev) ? 2'd2 : 2'd1;
    end else if (bv) begin
      step_o.r0  = b_item;
      step_o.r1  = e_item;
      step_o.cnt = ev ? 2'd2 : 2'd1;
    end else if (ev) begin
      step_o.r0  = e_item;
      step_o.cnt = 2'd1;
    end
    step_o.r0.last_of_run = (step_o.cnt == 2'd1);
    step_o.r1.last_of_run = 1'b1;
  end

endmodule

`default_nettype wire

@@ rtl/command_line_arg_splitter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A byte's result words are written into the 4-entry output queue when it is accepted and are
// offered on out_o from that registered queue, behind any older words still waiting there.
// Throughput: one byte per cycle while bytes yield one word each and out_stall_i stays low; out_o
// moves one word per cycle unless stalled, and the input stalls once three or more words are queued.
// Reset (rst_ni low, asynchronous): mode returns to between tokens, the queue empties;
// queue storage itself is not reset.

module command_line_arg_splitter (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          in_valid_i,
  output var logic          in_stall_o,
  input  var cla_pkg::in_t  in_i,
  output var logic          out_valid_o,
  input  var logic          out_stall_i,
  output var cla_pkg::out_t out_o
);

  localparam int unsigned PtrW = $clog2(cla_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(cla_pkg::QueueDepth + 1);

  logic [2:0]      mode_q, mode_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cla_pkg::out_t   queue_q [cla_pkg::QueueDepth];
  cla_pkg::step_t  step;
  logic            in_acc;
  logic            out_acc;
  logic [1:0]      push_cnt;

  // Byte decode: current mode plus the incoming byte give the next mode
  // and zero, one or two result words.
  cla_step u_step (
    .item_i (in_i),
    .mode_i (mode_q),
    .step_o (step)
  );

  // Room for the worst case of two words must exist before a byte is taken.
  assign in_stall_o  = (cnt_q > CntW'(cla_pkg::QueueDepth - 2));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_o       = queue_q[rd_ptr_q];
  assign push_cnt    = in_acc ? step.cnt : 2'd0;

  always_comb begin
    mode_d   = in_acc ? step.mode : mode_q;
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(out_acc);
    cnt_d    = cnt_q + CntW'(push_cnt) - CntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= cla_pkg::ModeIdle;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage: first word at the write pointer, second right after it.
  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      queue_q[wr_ptr_q] <= step.r0;
    end
    if (push_cnt == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= step.r1;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(cla_pkg::QueueDepth))
    else $error("output queue overflow");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + CntW'($past(push_cnt)) - CntW'($past(out_acc)))
    else $error("queue count out of step with pushes and pops");

  a_line_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.line_end |=> mode_q == cla_pkg::ModeIdle)
    else $error("mode not idle after line end");

  a_run_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt == 2'd1 |-> step.r0.last_of_run)
    else $error("single result word not marked last of run");
`endif

endmodule

`default_nettype wire
